// ===== design/ord_pkg.sv =====
// Shared types and constants for the overwriting ring deque.
package ord_pkg;

  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 32;
  localparam int unsigned CAP_RESET      = 16;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OFFSET_W    = 4;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 5;
  localparam int unsigned CAP_W       = 5;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK_FRONT = 3'd4,
    OP_PEEK_BACK  = 3'd5
  } op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_READ = 1'b1
  } state_e;

endpackage

// ===== design/ord_mem.sv =====
// Slot storage: one synchronous single-port memory with registered read data.
module ord_mem #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32,
  localparam int unsigned IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic                  re_i,
  input  logic [IW-1:0]         addr_i,
  input  logic [ELEM_WIDTH-1:0] wdata_i,
  output logic [ELEM_WIDTH-1:0] rdata_o
);

  logic [ELEM_WIDTH-1:0] mem_q [DEPTH];
  logic [ELEM_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/ord_ctrl.sv =====
// Deque control: index and count update, memory access and the result register.
module ord_ctrl
  import ord_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF,
  localparam int unsigned IW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW        = $clog2(DEPTH + 1)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clear_i,
  input  logic [CW-1:0]          cap_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                   mem_we_o,
  output logic                   mem_re_o,
  output logic [IW-1:0]          mem_addr_o,
  output logic [ELEM_WIDTH-1:0]  mem_wdata_o,
  input  logic [ELEM_WIDTH-1:0]  mem_rdata_i
);

  localparam int unsigned SW = ((CW > OFFSET_W) ? CW : OFFSET_W) + 1;

  state_e st_q, st_d;
  logic [IW-1:0] front_q, front_d, back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic          m_valid_q, m_valid_d;

  logic [DATA_W-1:0] res_data_q, res_data_d;
  logic              res_valid_q, res_valid_d;
  logic              res_over_q, res_over_d;
  logic [CW-1:0]     res_count_q, res_count_d;
  logic              res_empty_q, res_empty_d;
  logic              res_full_q, res_full_d;

  op_e               op;
  logic [VALUE_W-1:0]  value;
  logic [OFFSET_W-1:0] offset;
  logic              accept, out_free, full, empty, rd;
  logic [SW-1:0]     cap_w, inc_f, inc_b, pos_f, pos_b;
  logic [IW-1:0]     cap_m1, front_inc, front_dec, back_inc, back_dec, peek_f, peek_b;
  logic [ELEM_WIDTH+VALUE_W-1:0] wext;
  logic [ELEM_WIDTH+DATA_W-1:0]  rext;
  logic [CW+COUNT_W-1:0]         cext;

  assign op     = op_e'(s_axis_tdata[OP_W-1:0]);
  assign value  = s_axis_tdata[OP_W +: VALUE_W];
  assign offset = s_axis_tdata[OP_W+VALUE_W +: OFFSET_W];

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign full  = (count_q == cap_i);
  assign empty = (count_q == '0);

  // Ring arithmetic modulo the active capacity.
  assign cap_w     = SW'(cap_i);
  assign cap_m1    = cap_w[IW-1:0] - IW'(1);
  assign inc_f     = SW'(front_q) + SW'(1);
  assign inc_b     = SW'(back_q) + SW'(1);
  assign front_inc = (inc_f >= cap_w) ? '0 : inc_f[IW-1:0];
  assign back_inc  = (inc_b >= cap_w) ? '0 : inc_b[IW-1:0];
  assign front_dec = (front_q == '0) ? cap_m1 : front_q - IW'(1);
  assign back_dec  = (back_q == '0) ? cap_m1 : back_q - IW'(1);

  // Both peek positions stay below twice the capacity, so one subtract wraps them.
  assign pos_f  = SW'(front_q) + SW'(offset);
  assign pos_b  = SW'(back_q) + cap_w - SW'(1) - SW'(offset);
  assign peek_f = (pos_f >= cap_w) ? IW'(pos_f - cap_w) : pos_f[IW-1:0];
  assign peek_b = (pos_b >= cap_w) ? IW'(pos_b - cap_w) : pos_b[IW-1:0];

  assign wext        = {{ELEM_WIDTH{1'b0}}, value};
  assign mem_wdata_o = wext[ELEM_WIDTH-1:0];
  assign rext        = {{DATA_W{1'b0}}, mem_rdata_i};

  always_comb begin
    st_d        = st_q;
    front_d     = front_q;
    back_d      = back_q;
    count_d     = count_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    res_data_d  = res_data_q;
    res_valid_d = res_valid_q;
    res_over_d  = res_over_q;
    res_count_d = res_count_q;
    res_empty_d = res_empty_q;
    res_full_d  = res_full_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_addr_o  = front_q;
    rd          = 1'b0;

    if (st_q == ST_READ) begin
      res_data_d = rext[DATA_W-1:0];
      m_valid_d  = 1'b1;
      st_d       = ST_IDLE;
    end

    if (accept) begin
      res_over_d = 1'b0;
      case (op)
        OP_PUSH_FRONT: begin
          mem_we_o   = 1'b1;
          mem_addr_o = front_dec;
          front_d    = front_dec;
          if (full) begin
            back_d     = back_dec;
            res_over_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          mem_we_o   = 1'b1;
          mem_addr_o = back_q;
          back_d     = back_inc;
          if (full) begin
            front_d    = front_inc;
            res_over_d = 1'b1;
          end else begin
            count_d = count_q + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (!empty) begin
            rd         = 1'b1;
            mem_addr_o = front_q;
            front_d    = front_inc;
            count_d    = count_q - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (!empty) begin
            rd         = 1'b1;
            mem_addr_o = back_dec;
            back_d     = back_dec;
            count_d    = count_q - CW'(1);
          end
        end
        OP_PEEK_FRONT: begin
          if (SW'(offset) < SW'(count_q)) begin
            rd         = 1'b1;
            mem_addr_o = peek_f;
          end
        end
        OP_PEEK_BACK: begin
          if (SW'(offset) < SW'(count_q)) begin
            rd         = 1'b1;
            mem_addr_o = peek_b;
          end
        end
        default: begin
        end
      endcase
      mem_re_o    = rd;
      res_valid_d = rd;
      res_data_d  = '0;
      res_count_d = count_d;
      res_empty_d = (count_d == '0);
      res_full_d  = (count_d == cap_i);
      // A read result waits in ST_READ for the memory; every other result is registered now.
      st_d        = rd ? ST_READ : ST_IDLE;
      m_valid_d   = !rd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_IDLE;
      front_q   <= '0;
      back_q    <= '0;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      m_valid_q <= m_valid_d;
      if (clear_i) begin
        front_q <= '0;
        back_q  <= '0;
        count_q <= '0;
      end else begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_data_q  <= res_data_d;
    res_valid_q <= res_valid_d;
    res_over_q  <= res_over_d;
    res_count_q <= res_count_d;
    res_empty_q <= res_empty_d;
    res_full_q  <= res_full_d;
  end

  assign cext          = {{COUNT_W{1'b0}}, res_count_q};
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {7'b0, res_full_q, res_empty_q, cext[COUNT_W-1:0],
                          res_over_q, res_valid_q, res_data_q};

endmodule

// ===== design/overwriting_ring_deque.sv =====
// Top level of the overwriting ring deque: capacity register, control and slot memory.
//
// A pop or peek that finds an element waits in ST_READ for the registered slot read;
// any other op completes without one. One operation is in flight at a time. A new
// operation is taken only when the output register is empty or its result transfers
// in that same cycle, so a waiting result holds off the input. Writing the capacity
// (clamped to 1..DEPTH) empties the deque at once.
module overwriting_ring_deque
  import ord_pkg::*;
#(
  parameter int unsigned DEPTH      = DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ELEM_WIDTH_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CAP_W-1:0]       cfg_wdata_i,   // capacity
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // op[2:0], value[34:3], offset[38:35], zero[39]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // data[31:0], valid_res[32], overwrote[33], count[38:34], is_empty[39],
  // is_full[40], zero[47:41]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned KW = (CW > CAP_W) ? CW : CAP_W;
  localparam int unsigned CAP_RST = (CAP_RESET < DEPTH) ? CAP_RESET : DEPTH;

  logic [CW-1:0]         cap_q, cap_d;
  logic [KW-1:0]         cfg_ext, cap_clamp;
  logic                  mem_we, mem_re;
  logic [IW-1:0]         mem_addr;
  logic [ELEM_WIDTH-1:0] mem_wdata, mem_rdata;

  assign cfg_ext   = KW'(cfg_wdata_i);
  assign cap_clamp = (cfg_ext == '0) ? KW'(1) :
                     (cfg_ext > KW'(DEPTH)) ? KW'(DEPTH) : cfg_ext;
  assign cap_d     = cap_clamp[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CW'(CAP_RST);
    end else if (cfg_we_i) begin
      cap_q <= cap_d;
    end
  end

  ord_ctrl #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .clear_i       (cfg_we_i),
    .cap_i         (cap_q),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mem_we_o      (mem_we),
    .mem_re_o      (mem_re),
    .mem_addr_o    (mem_addr),
    .mem_wdata_o   (mem_wdata),
    .mem_rdata_i   (mem_rdata)
  );

  ord_mem #(
    .DEPTH      (DEPTH),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

endmodule
